// File: hdl/dttp_pkg.sv
// Shared types, codes and month table for the date/time text parser.
package dttp_pkg;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FMT  = 2'd1;
	localparam logic [1:0] ST_DATE = 2'd2;
	localparam logic [1:0] ST_TIME = 2'd3;

	localparam logic [2:0] FLD_NONE   = 3'd0;
	localparam logic [2:0] FLD_YEAR   = 3'd1;
	localparam logic [2:0] FLD_MONTH  = 3'd2;
	localparam logic [2:0] FLD_DAY    = 3'd3;
	localparam logic [2:0] FLD_HOUR   = 3'd4;
	localparam logic [2:0] FLD_MINUTE = 3'd5;
	localparam logic [2:0] FLD_SECOND = 3'd6;

	localparam logic [4:0] DATE_LEN     = 5'd10;
	localparam logic [4:0] DATETIME_LEN = 5'd19;
	localparam logic [4:0] POS_SAT      = 5'd20;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} src_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} res_item_t;

	// one classified character
	typedef struct packed {
		logic [2:0] fld;
		logic [3:0] digit;
		logic       bad;
		logic       last;
		logic       len_ok;
		logic       tm;
	} tok_t;

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd1:    d = 5'd31;
			4'd2:    d = leap ? 5'd29 : 5'd28;
			4'd3:    d = 5'd31;
			4'd4:    d = 5'd30;
			4'd5:    d = 5'd31;
			4'd6:    d = 5'd30;
			4'd7:    d = 5'd31;
			4'd8:    d = 5'd31;
			4'd9:    d = 5'd30;
			4'd10:   d = 5'd31;
			4'd11:   d = 5'd30;
			4'd12:   d = 5'd31;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

// File: hdl/dttp_front.sv
// Front end: character position tracking and classification into tokens.
module dttp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_data,
	input  logic                push,
	input  dttp_pkg::src_item_t item,
	output dttp_pkg::tok_t      tok
);

	logic       with_time_q;
	logic [4:0] pos_q;
	logic [4:0] need;
	logic       is_digit;
	logic [7:0] dg_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			with_time_q <= 1'b0;
		end else if (cfg_we) begin
			with_time_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
		end else if (push) begin
			if (item.last_char) begin
				pos_q <= 5'd0;
			end else if (pos_q < dttp_pkg::POS_SAT) begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	assign need     = with_time_q ? dttp_pkg::DATETIME_LEN : dttp_pkg::DATE_LEN;
	assign is_digit = (item.char_code >= dttp_pkg::CH_ZERO) &&
	                  (item.char_code <= dttp_pkg::CH_NINE);
	assign dg_full  = item.char_code - dttp_pkg::CH_ZERO;

	always_comb begin
		tok.fld    = dttp_pkg::FLD_NONE;
		tok.digit  = dg_full[3:0];
		tok.bad    = 1'b0;
		tok.last   = item.last_char;
		tok.len_ok = (pos_q + 5'd1) == need;
		tok.tm     = with_time_q;
		if (pos_q >= need) begin
			tok.bad = 1'b1;
		end else begin
			case (pos_q)
				5'd4, 5'd7:   tok.bad = item.char_code != dttp_pkg::CH_DASH;
				5'd10:        tok.bad = item.char_code != dttp_pkg::CH_SPACE;
				5'd13, 5'd16: tok.bad = item.char_code != dttp_pkg::CH_COLON;
				default: begin
					if (!is_digit) begin
						tok.bad = 1'b1;
					end else if (pos_q < 5'd4) begin
						tok.fld = dttp_pkg::FLD_YEAR;
					end else if (pos_q < 5'd7) begin
						tok.fld = dttp_pkg::FLD_MONTH;
					end else if (pos_q < 5'd10) begin
						tok.fld = dttp_pkg::FLD_DAY;
					end else if (pos_q < 5'd13) begin
						tok.fld = dttp_pkg::FLD_HOUR;
					end else if (pos_q < 5'd16) begin
						tok.fld = dttp_pkg::FLD_MINUTE;
					end else begin
						tok.fld = dttp_pkg::FLD_SECOND;
					end
				end
			endcase
		end
	end

endmodule

// File: hdl/dttp_queue.sv
// Small token queue between front and back ends.
module dttp_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dttp_pkg::tok_t wr_tok,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output dttp_pkg::tok_t rd_tok
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	dttp_pkg::tok_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = count_q == DEPTH_C;
	assign rd_valid = count_q != '0;
	assign rd_tok   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/dttp_back.sv
// Back end: field accumulation, range checks and the result register.
module dttp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	input  dttp_pkg::tok_t       tok,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output dttp_pkg::res_item_t  res_item
);

	logic        bad_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;
	logic [15:0] ydig_q;

	logic [13:0] year_n;
	logic [6:0]  month_n, day_n, hour_n, minute_n, second_n;
	logic [15:0] ydig_n;
	logic        bad_n;
	logic [4:0]  lo_sum, hi_sum;
	logic        leap, m_ok, date_ok, time_ok;
	logic [4:0]  dmax;
	logic [1:0]  status;
	logic        res_valid_q;
	dttp_pkg::res_item_t res_q;
	dttp_pkg::res_item_t res_n;

	function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
		return (a << 3) + (a << 1) + {3'd0, d};
	endfunction

	assign pop = tok_valid && (!tok.last || !res_valid_q || !res_stall);

	always_comb begin
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		ydig_n   = ydig_q;
		case (tok.fld)
			dttp_pkg::FLD_YEAR: begin
				year_n = (year_q << 3) + (year_q << 1) + {10'd0, tok.digit};
				ydig_n = {ydig_q[11:0], tok.digit};
			end
			dttp_pkg::FLD_MONTH:  month_n  = acc7(month_q, tok.digit);
			dttp_pkg::FLD_DAY:    day_n    = acc7(day_q, tok.digit);
			dttp_pkg::FLD_HOUR:   hour_n   = acc7(hour_q, tok.digit);
			dttp_pkg::FLD_MINUTE: minute_n = acc7(minute_q, tok.digit);
			dttp_pkg::FLD_SECOND: second_n = acc7(second_q, tok.digit);
			default: ;
		endcase
		bad_n = bad_q | tok.bad;
	end

	// leap test on decimal digits: 10*t+u mod 4 == 2*t+u mod 4
	assign lo_sum  = {ydig_n[7:4], 1'b0} + {1'b0, ydig_n[3:0]};
	assign hi_sum  = {ydig_n[15:12], 1'b0} + {1'b0, ydig_n[11:8]};
	assign leap    = (lo_sum[1:0] == 2'd0) &&
	                 ((ydig_n[7:0] != 8'd0) || (hi_sum[1:0] == 2'd0));
	assign m_ok    = (month_n >= 7'd1) && (month_n <= 7'd12);
	assign dmax    = dttp_pkg::days_in_month(month_n[3:0], leap);
	assign date_ok = m_ok && (day_n >= 7'd1) && (day_n <= {2'd0, dmax});
	assign time_ok = (hour_n <= 7'd23) && (minute_n <= 7'd59) && (second_n <= 7'd59);

	always_comb begin
		if (bad_n || !tok.len_ok) begin
			status = dttp_pkg::ST_FMT;
		end else if (!date_ok) begin
			status = dttp_pkg::ST_DATE;
		end else if (tok.tm && !time_ok) begin
			status = dttp_pkg::ST_TIME;
		end else begin
			status = dttp_pkg::ST_OK;
		end
	end

	always_comb begin
		res_n        = '0;
		res_n.status = status;
		if (status != dttp_pkg::ST_FMT) begin
			res_n.year  = year_n;
			res_n.month = month_n;
			res_n.day   = day_n;
			if (tok.tm) begin
				res_n.hour   = hour_n;
				res_n.minute = minute_n;
				res_n.second = second_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			ydig_q   <= '0;
		end else if (pop) begin
			if (tok.last) begin
				bad_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				ydig_q   <= '0;
			end else begin
				bad_q    <= bad_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				ydig_q   <= ydig_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && tok.last) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// File: hdl/date_time_text_parser.sv
// Top level of the date/time text parser.
// Usage:
//   Text enters one ASCII character per transfer on the src channel
//   (src_valid/src_stall/src_item); last_char marks the final character.
//   Each string yields one transfer on the res channel with status and the
//   decimal fields. cfg_we/cfg_data write with_time (0 date only, 1 date and
//   time); write it only while no string is in flight.
// Throughput: one character per cycle while src_stall is low. The front end tags each
//   character with its field and checks separators and digits, then pushes it into a
//   QUEUE_DEPTH-entry token queue; the back end accumulates and range-checks.
// Result path: the last character's token is written to the queue and popped by the
//   back end, which then loads the result register and raises res_valid.
// Stall: while res_stall holds a result, the back end keeps consuming
//   non-final characters; the queue fills and src_stall rises only when it is
//   full. A new result is loaded in the cycle the old one is taken.
// Reset: arst_n clears position, accumulators, queue and result valid;
//   with_time resets to date only.
module date_time_text_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  dttp_pkg::src_item_t src_item,
	output logic                res_valid,
	input  logic                res_stall,
	output dttp_pkg::res_item_t res_item,
	input  logic                cfg_we,
	input  logic                cfg_data
);

	logic           q_full;
	logic           push;
	logic           pop;
	logic           tok_valid;
	dttp_pkg::tok_t front_tok;
	dttp_pkg::tok_t back_tok;

	assign src_stall = q_full;
	assign push      = src_valid && !q_full;

	dttp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (src_item),
		.tok      (front_tok)
	);

	dttp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_tok   (front_tok),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (tok_valid),
		.rd_tok   (back_tok)
	);

	dttp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (back_tok),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	a_fmt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == dttp_pkg::ST_FMT |->
			res_item.year == '0 && res_item.month == '0 && res_item.day == '0 &&
			res_item.hour == '0 && res_item.minute == '0 && res_item.second == '0)
		else $error("format error result carries nonzero fields");

	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.status == dttp_pkg::ST_OK ||
		              res_item.status == dttp_pkg::ST_TIME) |->
			res_item.month >= 7'd1 && res_item.month <= 7'd12 &&
			res_item.day >= 7'd1 && res_item.day <= 7'd31)
		else $error("date passed with month or day out of range");

	a_ok_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == dttp_pkg::ST_OK |->
			res_item.hour <= 7'd23 && res_item.minute <= 7'd59 &&
			res_item.second <= 7'd59)
		else $error("valid result with time out of range");

	a_pop_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> tok_valid)
		else $error("token popped from empty queue");

endmodule
